// ===== hw/rtl/vxs_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel store package
// Field widths, operation codes and shared types of the voxel store.
// ----------------------------------------------------------------------------
package vxs_pkg;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned POS_XZ_W    = 4;
  localparam int unsigned POS_Y_W     = 7;
  localparam int unsigned TYPE_W      = 8;
  localparam int unsigned ATTR_W      = 8;
  localparam int unsigned TOP_W       = 7;
  localparam int unsigned CFG_W       = 8;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE  = 2'd0,
    MODE_READ   = 2'd1,
    MODE_HEIGHT = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  // OP_NULL: coordinate outside the grid, nothing changes
  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_READ   = 3'd1,
    OP_HEIGHT = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_NULL   = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AIR_CODE     = 1'b0,
    CFG_DEFAULT_ATTR = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [TYPE_W-1:0] cell_type;
    logic [ATTR_W-1:0] cell_attr;
    logic [TOP_W-1:0]  column_top;
    logic              column_empty;
  } rsp_t;

  localparam rsp_t RSP_NONE = '{cell_type: '0, cell_attr: '0, column_top: '0,
                                column_empty: 1'b1};

endpackage

// ===== hw/rtl/vxs_if.sv =====
// ----------------------------------------------------------------------------
// Voxel store channels
// Request and response channels, valid/ready with payload.
// ----------------------------------------------------------------------------
interface vxs_req_if import vxs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [POS_XZ_W-1:0] pos_x;
  logic [POS_Y_W-1:0]  pos_y;
  logic [POS_XZ_W-1:0] pos_z;
  logic [TYPE_W-1:0]   new_type;
  logic [ATTR_W-1:0]   new_attr;

  modport source (output valid, mode, pos_x, pos_y, pos_z, new_type, new_attr,
                  input ready);
  modport sink   (input valid, mode, pos_x, pos_y, pos_z, new_type, new_attr,
                  output ready);
endinterface

interface vxs_rsp_if import vxs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] cell_type;
  logic [ATTR_W-1:0] cell_attr;
  logic [TOP_W-1:0]  column_top;
  logic              column_empty;

  modport source (output valid, cell_type, cell_attr, column_top, column_empty,
                  input ready);
  modport sink   (input valid, cell_type, cell_attr, column_top, column_empty,
                  output ready);
endinterface

// ===== hw/rtl/vxs_front.sv =====
// ----------------------------------------------------------------------------
// Voxel store front end
// Accepts request beats, range-checks coordinates, decodes the operation and
// forms the column index and the column base address for the back end.
// ----------------------------------------------------------------------------
module vxs_front import vxs_pkg::*; #(
  parameter int unsigned GRID_WIDTH  = 16,
  parameter int unsigned GRID_HEIGHT = 128,
  parameter type         cmd_t       = logic
) (
  vxs_req_if.sink req_i,
  output logic    cmd_valid_o,
  input  logic    cmd_ready_i,
  output cmd_t    cmd_o
);

  localparam int unsigned COLS   = GRID_WIDTH * GRID_WIDTH;
  localparam int unsigned CELLS  = COLS * GRID_HEIGHT;
  localparam int unsigned COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned Y_W    = $clog2(GRID_HEIGHT);

  logic col_ok;
  logic cell_ok;
  int   col_idx;

  assign cmd_valid_o = req_i.valid;
  assign req_i.ready = cmd_ready_i;

  always_comb begin
    col_ok  = (int'(req_i.pos_x) < int'(GRID_WIDTH)) &&
              (int'(req_i.pos_z) < int'(GRID_WIDTH));
    cell_ok = col_ok && (int'(req_i.pos_y) < int'(GRID_HEIGHT));
    col_idx = int'(req_i.pos_x) * int'(GRID_WIDTH) + int'(req_i.pos_z);

    cmd_o.col      = COL_W'(col_idx);
    cmd_o.base     = ADDR_W'(col_idx * int'(GRID_HEIGHT));
    cmd_o.y        = req_i.pos_y[Y_W-1:0];
    cmd_o.new_type = req_i.new_type;
    cmd_o.new_attr = req_i.new_attr;

    unique case (mode_e'(req_i.mode))
      MODE_WRITE:  cmd_o.op = cell_ok ? OP_WRITE  : OP_NULL;
      MODE_READ:   cmd_o.op = cell_ok ? OP_READ   : OP_NULL;
      MODE_HEIGHT: cmd_o.op = col_ok  ? OP_HEIGHT : OP_NULL;
      MODE_CLEAR:  cmd_o.op = OP_CLEAR;
      default:     cmd_o.op = OP_NULL;
    endcase
  end

endmodule

// ===== hw/rtl/vxs_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Voxel store command queue
// Short FIFO between front and back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module vxs_cmd_fifo import vxs_pkg::*; #(
  parameter type data_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  data_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output data_t pop_data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  data_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/vxs_back.sv =====
// ----------------------------------------------------------------------------
// Voxel store back end
// Owns the cell stores and the height map, runs one command at a time:
// column fill, cell write, top-down column scan, lookups, clear.
// ----------------------------------------------------------------------------
module vxs_back import vxs_pkg::*; #(
  parameter int unsigned GRID_WIDTH  = 16,
  parameter int unsigned GRID_HEIGHT = 128,
  parameter type         cmd_t       = logic
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TYPE_W-1:0] air_code_i,
  input  logic [ATTR_W-1:0] default_attr_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  vxs_rsp_if.source         rsp_o
);

  localparam int unsigned COLS   = GRID_WIDTH * GRID_WIDTH;
  localparam int unsigned CELLS  = COLS * GRID_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned Y_W    = $clog2(GRID_HEIGHT);
  localparam logic [Y_W-1:0] Y_TOP = Y_W'(GRID_HEIGHT - 1);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_DISPATCH = 6'b000010,
    ST_FILL     = 6'b000100,
    ST_SCAN     = 6'b001000,
    ST_LOOKUP   = 6'b010000,
    ST_DONE     = 6'b100000
  } state_e;

  typedef struct packed {
    logic           empty;
    logic [Y_W-1:0] top;
  } col_entry_t;

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [Y_W-1:0]    y_q, y_d;
  logic              chk_vld_q, chk_vld_d;
  logic [Y_W-1:0]    chk_y_q, chk_y_d;
  rsp_t              rsp_q, rsp_d;
  rsp_t              out_q, out_d;
  logic              out_vld_q, out_vld_d;
  logic [COLS-1:0]   col_valid_q, col_valid_d;
  logic [TYPE_W-1:0] fill_type_q, fill_type_d;
  logic [ATTR_W-1:0] fill_attr_q, fill_attr_d;

  // storage
  logic [TYPE_W-1:0] type_mem [CELLS];
  logic [ATTR_W-1:0] attr_mem [CELLS];
  col_entry_t        col_mem  [COLS];
  logic [TYPE_W-1:0] type_rd_q;
  logic [ATTR_W-1:0] attr_rd_q;
  col_entry_t        col_rd_q;

  logic              cell_we;
  logic [Y_W-1:0]    cell_wy;
  logic [TYPE_W-1:0] cell_wtype;
  logic [ATTR_W-1:0] cell_wattr;
  logic [Y_W-1:0]    cell_ry;
  logic [ADDR_W-1:0] cell_waddr;
  logic [ADDR_W-1:0] cell_raddr;
  logic              col_we;
  col_entry_t        col_wdata;
  logic              col_vld;

  assign cell_waddr = cmd_q.base + ADDR_W'(cell_wy);
  assign cell_raddr = cmd_q.base + ADDR_W'(cell_ry);
  assign col_vld    = col_valid_q[cmd_q.col];

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.cell_type    = out_q.cell_type;
  assign rsp_o.cell_attr    = out_q.cell_attr;
  assign rsp_o.column_top   = out_q.column_top;
  assign rsp_o.column_empty = out_q.column_empty;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    y_d         = y_q;
    chk_vld_d   = chk_vld_q;
    chk_y_d     = chk_y_q;
    rsp_d       = rsp_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q;
    col_valid_d = col_valid_q;
    fill_type_d = fill_type_q;
    fill_attr_d = fill_attr_q;
    cmd_ready_o = 1'b0;
    cell_we     = 1'b0;
    cell_wy     = cmd_q.y;
    cell_wtype  = cmd_q.new_type;
    cell_wattr  = cmd_q.new_attr;
    cell_ry     = cmd_q.y;
    col_we      = 1'b0;
    col_wdata   = '{empty: 1'b1, top: '0};

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          state_d = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        unique case (cmd_q.op)
          OP_CLEAR: begin
            // columns not yet touched since clear read back as fill bytes
            col_valid_d = '0;
            fill_type_d = air_code_i;
            fill_attr_d = default_attr_i;
            rsp_d       = RSP_NONE;
            state_d     = ST_DONE;
          end
          OP_HEIGHT: begin
            rsp_d   = RSP_NONE;
            state_d = col_vld ? ST_LOOKUP : ST_DONE;
          end
          OP_READ: begin
            if (col_vld) begin
              state_d = ST_LOOKUP;
            end else begin
              rsp_d           = RSP_NONE;
              rsp_d.cell_type = fill_type_q;
              rsp_d.cell_attr = fill_attr_q;
              state_d         = ST_DONE;
            end
          end
          OP_WRITE: begin
            y_d       = Y_TOP;
            chk_vld_d = 1'b0;
            if (col_vld) begin
              cell_we = 1'b1;
              state_d = ST_SCAN;
            end else begin
              state_d = ST_FILL;
            end
          end
          default: begin
            rsp_d   = RSP_NONE;
            state_d = ST_DONE;
          end
        endcase
      end

      // materialize a column that still holds fill bytes, placing the new cell
      ST_FILL: begin
        cell_we = 1'b1;
        cell_wy = y_q;
        if (y_q != cmd_q.y) begin
          cell_wtype = fill_type_q;
          cell_wattr = fill_attr_q;
        end
        if (y_q == '0) begin
          col_valid_d[cmd_q.col] = 1'b1;
          y_d                    = Y_TOP;
          state_d                = ST_SCAN;
        end else begin
          y_d = y_q - 1'b1;
        end
      end

      // one read issued per cycle, checked in the following cycle
      ST_SCAN: begin
        cell_ry = y_q;
        if (chk_vld_q && (type_rd_q != air_code_i)) begin
          col_we          = 1'b1;
          col_wdata       = '{empty: 1'b0, top: chk_y_q};
          rsp_d.cell_type    = cmd_q.new_type;
          rsp_d.cell_attr    = cmd_q.new_attr;
          rsp_d.column_top   = TOP_W'(chk_y_q);
          rsp_d.column_empty = 1'b0;
          state_d            = ST_DONE;
        end else if (chk_vld_q && (chk_y_q == '0)) begin
          col_we             = 1'b1;
          rsp_d.cell_type    = cmd_q.new_type;
          rsp_d.cell_attr    = cmd_q.new_attr;
          rsp_d.column_top   = '0;
          rsp_d.column_empty = 1'b1;
          state_d            = ST_DONE;
        end else begin
          chk_vld_d = 1'b1;
          chk_y_d   = y_q;
          if (y_q != '0) begin
            y_d = y_q - 1'b1;
          end
        end
      end

      ST_LOOKUP: begin
        rsp_d.column_top   = TOP_W'(col_rd_q.top);
        rsp_d.column_empty = col_rd_q.empty;
        if (cmd_q.op == OP_READ) begin
          rsp_d.cell_type = type_rd_q;
          rsp_d.cell_attr = attr_rd_q;
        end else begin
          rsp_d.cell_type = '0;
          rsp_d.cell_attr = '0;
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_d     = rsp_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chk_vld_q   <= 1'b0;
      out_vld_q   <= 1'b0;
      col_valid_q <= '0;
      fill_type_q <= '0;
      fill_attr_q <= '0;
    end else begin
      state_q     <= state_d;
      chk_vld_q   <= chk_vld_d;
      out_vld_q   <= out_vld_d;
      col_valid_q <= col_valid_d;
      fill_type_q <= fill_type_d;
      fill_attr_q <= fill_attr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    y_q     <= y_d;
    chk_y_q <= chk_y_d;
    rsp_q   <= rsp_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      type_mem[cell_waddr] <= cell_wtype;
    end
    type_rd_q <= type_mem[cell_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      attr_mem[cell_waddr] <= cell_wattr;
    end
    attr_rd_q <= attr_mem[cell_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[cmd_q.col] <= col_wdata;
    end
    col_rd_q <= col_mem[cmd_q.col];
  end

endmodule

// ===== hw/rtl/voxel_store_with_heightmap.sv =====
// A block or height read into a column untouched since clear is answered without
//   a lookup; a write into an untouched column fills it before the scan.
// Throughput: one item in the back end at a time; an untouched column is filled
//   first, then the scan reads one cell per cycle top-down. Two commands queue.
// Reset: control cleared, columns untouched, reading as air 0 and attribute 0.
// ----------------------------------------------------------------------------
// Voxel store with height map
// Grid of type and attribute bytes with a per-column top height, fed through
// a decode front end, a command queue and a store back end.
// ----------------------------------------------------------------------------
module voxel_store_with_heightmap import vxs_pkg::*; #(
  parameter int unsigned GRID_WIDTH  = 16,
  parameter int unsigned GRID_HEIGHT = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  vxs_req_if.sink              req_i,
  vxs_rsp_if.source            rsp_o
);

  localparam int unsigned COLS   = GRID_WIDTH * GRID_WIDTH;
  localparam int unsigned CELLS  = COLS * GRID_HEIGHT;
  localparam int unsigned COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned Y_W    = $clog2(GRID_HEIGHT);

  typedef struct packed {
    op_e               op;
    logic [COL_W-1:0]  col;
    logic [ADDR_W-1:0] base;
    logic [Y_W-1:0]    y;
    logic [TYPE_W-1:0] new_type;
    logic [ATTR_W-1:0] new_attr;
  } cmd_t;

  logic [TYPE_W-1:0] air_code_q, air_code_d;
  logic [ATTR_W-1:0] default_attr_q, default_attr_d;

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic back_valid, back_ready;
  cmd_t back_cmd;

  always_comb begin
    air_code_d     = air_code_q;
    default_attr_d = default_attr_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_AIR_CODE:     air_code_d     = cfg_wdata_i[TYPE_W-1:0];
        CFG_DEFAULT_ATTR: default_attr_d = cfg_wdata_i[ATTR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      air_code_q     <= '0;
      default_attr_q <= '0;
    end else begin
      air_code_q     <= air_code_d;
      default_attr_q <= default_attr_d;
    end
  end

  vxs_front #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .cmd_t       (cmd_t)
  ) u_front (
    .req_i       (req_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  vxs_cmd_fifo #(
    .data_t (cmd_t)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_cmd)
  );

  vxs_back #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .cmd_t       (cmd_t)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .air_code_i     (air_code_q),
    .default_attr_i (default_attr_q),
    .cmd_valid_i    (back_valid),
    .cmd_ready_o    (back_ready),
    .cmd_i          (back_cmd),
    .rsp_o          (rsp_o)
  );

endmodule

// ===== tb/sv/tb_voxel_store_with_heightmap.sv =====
// ----------------------------------------------------------------------------
// Voxel store with height map testbench
// Drives commands through the request channel and checks every response
// against a cycle-free model of the grid, the column tops and the empty flags.
// Directed tests cover reset contents, the column scan, clear and a change of
// the air code; random traffic then runs under several register settings with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_voxel_store_with_heightmap;
  import vxs_pkg::*;

  localparam int unsigned GRID_W      = 16;
  localparam int unsigned GRID_H      = 128;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned RECENT_KEEP = 16;

  typedef struct packed {
    mode_e               mode;
    logic [POS_XZ_W-1:0] pos_x;
    logic [POS_Y_W-1:0]  pos_y;
    logic [POS_XZ_W-1:0] pos_z;
    logic [TYPE_W-1:0]   new_type;
    logic [ATTR_W-1:0]   new_attr;
  } voxel_cmd_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  vxs_req_if req_if ();
  vxs_rsp_if rsp_if ();

  voxel_store_with_heightmap #(
    .GRID_WIDTH  (GRID_W),
    .GRID_HEIGHT (GRID_H)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // model state
  logic [TYPE_W-1:0] air_now;
  logic [ATTR_W-1:0] attr_now;
  logic [TYPE_W-1:0] type_mem  [GRID_W][GRID_H][GRID_W];
  logic [ATTR_W-1:0] attr_mem  [GRID_W][GRID_H][GRID_W];
  logic [TOP_W-1:0]  top_mem   [GRID_W][GRID_W];
  logic              empty_mem [GRID_W][GRID_W];

  rsp_t       voxel_rsp_q[$];
  voxel_cmd_t recent_writes[$];

  logic [POS_XZ_W-1:0] hot_x [4];
  logic [POS_XZ_W-1:0] hot_z [4];
  logic [POS_Y_W-1:0]  hot_y [6];

  bit          no_idle;
  int unsigned mode_count [4];
  int unsigned emptied_by_write;
  int unsigned rsp_checked;
  int unsigned mismatches;
  int unsigned stray_rsp;
  int unsigned quiet_cycles;
  voxel_cmd_t  seen_cmd;
  rsp_t        seen_rsp;
  rsp_t        want_rsp;
  bit          field_bad;

  function automatic void refill_grid();
    for (int x = 0; x < GRID_W; x++) begin
      for (int z = 0; z < GRID_W; z++) begin
        for (int y = 0; y < GRID_H; y++) begin
          type_mem[x][y][z] = air_now;
          attr_mem[x][y][z] = attr_now;
        end
        top_mem[x][z]   = '0;
        empty_mem[x][z] = 1'b1;
      end
    end
  endfunction

  // top-down scan with the air code in force now
  function automatic void rescan_column(logic [POS_XZ_W-1:0] x, logic [POS_XZ_W-1:0] z);
    top_mem[x][z]   = '0;
    empty_mem[x][z] = 1'b1;
    for (int y = GRID_H - 1; y >= 0; y--) begin
      if (type_mem[x][y][z] != air_now) begin
        top_mem[x][z]   = TOP_W'(y);
        empty_mem[x][z] = 1'b0;
        break;
      end
    end
  endfunction

  function automatic rsp_t apply_voxel_cmd(voxel_cmd_t c);
    rsp_t r;
    r = RSP_NONE;
    mode_count[c.mode]++;
    case (c.mode)
      MODE_CLEAR: refill_grid();
      MODE_HEIGHT: begin
        r.column_top   = top_mem[c.pos_x][c.pos_z];
        r.column_empty = empty_mem[c.pos_x][c.pos_z];
      end
      default: begin
        if (c.mode == MODE_WRITE) begin
          type_mem[c.pos_x][c.pos_y][c.pos_z] = c.new_type;
          attr_mem[c.pos_x][c.pos_y][c.pos_z] = c.new_attr;
          rescan_column(c.pos_x, c.pos_z);
          if (empty_mem[c.pos_x][c.pos_z]) emptied_by_write++;
        end
        r.cell_type    = type_mem[c.pos_x][c.pos_y][c.pos_z];
        r.cell_attr    = attr_mem[c.pos_x][c.pos_y][c.pos_z];
        r.column_top   = top_mem[c.pos_x][c.pos_z];
        r.column_empty = empty_mem[c.pos_x][c.pos_z];
      end
    endcase
    return r;
  endfunction

  function automatic voxel_cmd_t make_cmd(mode_e m, int unsigned x, int unsigned y,
                                          int unsigned z, int unsigned t, int unsigned a);
    voxel_cmd_t c;
    c.mode     = m;
    c.pos_x    = POS_XZ_W'(x);
    c.pos_y    = POS_Y_W'(y);
    c.pos_z    = POS_XZ_W'(z);
    c.new_type = TYPE_W'(t);
    c.new_attr = ATTR_W'(a);
    return c;
  endfunction

  // biased toward a few columns and heights so that tops move up and down
  function automatic voxel_cmd_t random_cmd();
    voxel_cmd_t  c;
    int unsigned roll;
    int unsigned k;
    roll       = $urandom_range(0, 99);
    c.mode     = (roll < 45) ? MODE_WRITE : (roll < 75) ? MODE_READ :
                 (roll < 97) ? MODE_HEIGHT : MODE_CLEAR;
    c.pos_x    = POS_XZ_W'($urandom_range(0, GRID_W - 1));
    c.pos_y    = POS_Y_W'($urandom_range(0, GRID_H - 1));
    c.pos_z    = POS_XZ_W'($urandom_range(0, GRID_W - 1));
    c.new_type = TYPE_W'($urandom);
    c.new_attr = ATTR_W'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      k       = $urandom_range(0, 3);
      c.pos_x = hot_x[k];
      c.pos_z = hot_z[k];
    end
    if ($urandom_range(0, 4) < 2) c.pos_y = hot_y[$urandom_range(0, 5)];
    if ($urandom_range(0, 4) < 2) c.new_type = air_now;
    if (c.mode == MODE_READ && recent_writes.size() != 0 && $urandom_range(0, 1) == 1) begin
      k       = $urandom_range(0, recent_writes.size() - 1);
      c.pos_x = recent_writes[k].pos_x;
      c.pos_y = recent_writes[k].pos_y;
      c.pos_z = recent_writes[k].pos_z;
    end
    if (c.mode == MODE_WRITE) begin
      recent_writes.push_back(c);
      if (recent_writes.size() > RECENT_KEEP) void'(recent_writes.pop_front());
    end
    return c;
  endfunction

  // entered right after the previous beat, valid still high from it
  task automatic send_cmd(voxel_cmd_t c);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    @(negedge clk_i);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= c.mode;
    req_if.pos_x    <= c.pos_x;
    req_if.pos_y    <= c.pos_y;
    req_if.pos_z    <= c.pos_z;
    req_if.new_type <= c.new_type;
    req_if.new_attr <= c.new_attr;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic settle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (voxel_rsp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_AIR_CODE:     air_now  = val;
      CFG_DEFAULT_ATTR: attr_now = val;
      default: ;
    endcase
  endtask

  task automatic test_reset_state();
    send_cmd(make_cmd(MODE_READ, 0, 0, 0, 8'h5A, 8'hA5));
    send_cmd(make_cmd(MODE_READ, 15, 127, 15, 8'hFF, 8'hFF));
    send_cmd(make_cmd(MODE_HEIGHT, 15, 0, 15, 0, 0));
    send_cmd(make_cmd(MODE_HEIGHT, 0, 127, 0, 0, 0));
  endtask

  task automatic test_write_scan();
    send_cmd(make_cmd(MODE_WRITE, 3, 127, 5, 8'hFF, 8'hFF));
    send_cmd(make_cmd(MODE_WRITE, 3, 0, 5, 8'h07, 8'h80));
    // top goes back to air: scan walks down to the floor
    send_cmd(make_cmd(MODE_WRITE, 3, 127, 5, 8'h00, 8'h11));
    // last solid cell removed: column empty
    send_cmd(make_cmd(MODE_WRITE, 3, 0, 5, 8'h00, 8'h22));
    send_cmd(make_cmd(MODE_HEIGHT, 3, 127, 5, 0, 0));
    send_cmd(make_cmd(MODE_READ, 3, 127, 5, 0, 0));
    send_cmd(make_cmd(MODE_WRITE, 15, 64, 0, 8'h01, 8'h01));
    send_cmd(make_cmd(MODE_WRITE, 0, 127, 15, 8'h00, 8'hFF));
    send_cmd(make_cmd(MODE_HEIGHT, 15, 0, 0, 0, 0));
  endtask

  task automatic test_clear_fill();
    settle();
    write_cfg(CFG_AIR_CODE, 8'h3C);
    write_cfg(CFG_DEFAULT_ATTR, 8'hA5);
    send_cmd(make_cmd(MODE_CLEAR, 9, 42, 6, 8'h12, 8'h34));
    send_cmd(make_cmd(MODE_READ, 3, 127, 5, 0, 0));
    send_cmd(make_cmd(MODE_HEIGHT, 15, 0, 0, 0, 0));
    send_cmd(make_cmd(MODE_WRITE, 0, 5, 0, 8'h3C, 8'h01));
    send_cmd(make_cmd(MODE_WRITE, 0, 5, 0, 8'h00, 8'h02));
  endtask

  // stored bytes and tops stay; only later writes see the new air code
  task automatic test_air_code_change();
    settle();
    write_cfg(CFG_AIR_CODE, 8'h00);
    send_cmd(make_cmd(MODE_HEIGHT, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(MODE_READ, 15, 127, 15, 0, 0));
    send_cmd(make_cmd(MODE_WRITE, 1, 0, 1, 8'h00, 8'h00));
  endtask

  task automatic test_random_traffic(logic [7:0] air, logic [7:0] attr, bit start_clear,
                                     int unsigned n_cmds);
    settle();
    write_cfg(CFG_AIR_CODE, air);
    write_cfg(CFG_DEFAULT_ATTR, attr);
    for (int k = 0; k < 4; k++) begin
      hot_x[k] = POS_XZ_W'($urandom_range(0, GRID_W - 1));
      hot_z[k] = POS_XZ_W'($urandom_range(0, GRID_W - 1));
    end
    hot_y[0] = '0;
    hot_y[1] = POS_Y_W'(GRID_H - 1);
    hot_y[2] = POS_Y_W'(1);
    hot_y[3] = POS_Y_W'(GRID_H - 2);
    hot_y[4] = POS_Y_W'($urandom_range(0, GRID_H - 1));
    hot_y[5] = POS_Y_W'($urandom_range(0, GRID_H - 1));
    recent_writes.delete();
    if (start_clear) send_cmd(make_cmd(MODE_CLEAR, 0, 0, 0, 0, 0));
    for (int unsigned i = 0; i < n_cmds; i++) begin
      if ($urandom_range(0, 59) == 0) no_idle = !no_idle;
      send_cmd(random_cmd());
    end
    no_idle = 1'b0;
  endtask

  // response side: random stall before each beat
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      @(negedge clk_i);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        seen_cmd.mode     = mode_e'(req_if.mode);
        seen_cmd.pos_x    = req_if.pos_x;
        seen_cmd.pos_y    = req_if.pos_y;
        seen_cmd.pos_z    = req_if.pos_z;
        seen_cmd.new_type = req_if.new_type;
        seen_cmd.new_attr = req_if.new_attr;
        voxel_rsp_q.push_back(apply_voxel_cmd(seen_cmd));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        seen_rsp.cell_type    = rsp_if.cell_type;
        seen_rsp.cell_attr    = rsp_if.cell_attr;
        seen_rsp.column_top   = rsp_if.column_top;
        seen_rsp.column_empty = rsp_if.column_empty;
        if (voxel_rsp_q.size() == 0) begin
          stray_rsp++;
          if (mismatches + stray_rsp <= MAX_SHOWN)
            $display("%0t: response beat with nothing outstanding: type %02h attr %02h",
                     $time, seen_rsp.cell_type, seen_rsp.cell_attr);
        end else begin
          want_rsp  = voxel_rsp_q.pop_front();
          rsp_checked++;
          field_bad = (seen_rsp.cell_type    !== want_rsp.cell_type)  ||
                      (seen_rsp.cell_attr    !== want_rsp.cell_attr)  ||
                      (seen_rsp.column_top   !== want_rsp.column_top) ||
                      (seen_rsp.column_empty !== want_rsp.column_empty);
          if (field_bad) begin
            mismatches++;
            if (mismatches + stray_rsp <= MAX_SHOWN)
              $display("%0t: response %0d: want type %02h attr %02h top %0d empty %0b, got type %02h attr %02h top %0d empty %0b",
                       $time, rsp_checked, want_rsp.cell_type, want_rsp.cell_attr,
                       want_rsp.column_top, want_rsp.column_empty, seen_rsp.cell_type,
                       seen_rsp.cell_attr, seen_rsp.column_top, seen_rsp.column_empty);
          end
        end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("watchdog: no beat for %0d cycles, %0d responses outstanding",
                   quiet_cycles, voxel_rsp_q.size());
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_AIR_CODE;
    cfg_wdata_i     = '0;
    req_if.valid    = 1'b0;
    req_if.mode     = MODE_WRITE;
    req_if.pos_x    = '0;
    req_if.pos_y    = '0;
    req_if.pos_z    = '0;
    req_if.new_type = '0;
    req_if.new_attr = '0;
    no_idle         = 1'b0;
    air_now         = '0;
    attr_now        = '0;
    refill_grid();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_write_scan();
    test_clear_fill();
    test_air_code_change();
    test_random_traffic(8'hFF, 8'h00, 1'b1, 480);
    test_random_traffic(8'h00, 8'hFF, 1'b0, 480);
    test_random_traffic(8'($urandom), 8'($urandom), 1'b1, 480);

    settle();
    repeat (20) @(posedge clk_i);
    $display("covered: %0d writes, %0d block reads, %0d height reads, %0d clears",
             mode_count[MODE_WRITE], mode_count[MODE_READ], mode_count[MODE_HEIGHT],
             mode_count[MODE_CLEAR]);
    $display("covered: %0d responses checked, %0d writes emptied a column, %0d bad, %0d stray",
             rsp_checked, emptied_by_write, mismatches, stray_rsp);
    if (mismatches == 0 && stray_rsp == 0 && voxel_rsp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
